// ----- design/ihrc_pkg.sv -----
// Shared types and constants for the IPv4 receive header check.
// Holds the input and result item structs, verdict and route codes.
// No dependencies.
`default_nettype none

package ihrc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  route;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [15:0] total_length;
        logic [15:0] payload_length;
        logic [31:0] received_count;
        logic [31:0] dropped_count;
    } out_item_t;

    localparam logic [2:0] VERDICT_ACCEPT      = 3'd0;
    localparam logic [2:0] VERDICT_BAD_VERSION = 3'd1;
    localparam logic [2:0] VERDICT_FRAGMENTED  = 3'd2;
    localparam logic [2:0] VERDICT_WRONG_DEST  = 3'd3;
    localparam logic [2:0] VERDICT_BAD_CSUM    = 3'd4;

    localparam logic [1:0] ROUTE_ICMP  = 2'd0;
    localparam logic [1:0] ROUTE_UDP   = 2'd1;
    localparam logic [1:0] ROUTE_TCP   = 2'd2;
    localparam logic [1:0] ROUTE_OTHER = 2'd3;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [3:0]  IP_VERSION       = 4'd4;
    localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
    localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;

    localparam logic [5:0] POS_VERSION   = 6'd0;
    localparam logic [5:0] POS_LEN_HI    = 6'd2;
    localparam logic [5:0] POS_LEN_LO    = 6'd3;
    localparam logic [5:0] POS_FRAG_HI   = 6'd6;
    localparam logic [5:0] POS_FRAG_LO   = 6'd7;
    localparam logic [5:0] POS_PROTOCOL  = 6'd9;
    localparam logic [5:0] POS_SRC_FIRST = 6'd12;
    localparam logic [5:0] POS_SRC_LAST  = 6'd15;
    localparam logic [5:0] POS_DST_FIRST = 6'd16;
    localparam logic [5:0] POS_DST_LAST  = 6'd19;

    function automatic logic [1:0] route_of(input logic [7:0] proto);
        logic [1:0] r;
        case (proto)
            PROTO_ICMP: r = ROUTE_ICMP;
            PROTO_UDP:  r = ROUTE_UDP;
            PROTO_TCP:  r = ROUTE_TCP;
            default:    r = ROUTE_OTHER;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/ipv4_header_receive_check_core.sv -----
// IPv4 receive header check, top level: parser and result buffer.
// A result is registered in the main output stage, or parked in the skid stage while the output stalls.
// Throughput: one byte per cycle; the input stalls only when both result stages are full.
// Reset: asynchronous active low; clears counters, captured fields and the local
// address, and leaves the parser ignoring bytes until the first start marker.
// Depends on ihrc_pkg, ihrc_parser and ihrc_out_buf.
`default_nettype none

module ipv4_header_receive_check_core #(
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ihrc_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ihrc_pkg::out_item_t      out_item
);

    logic                item_take;
    logic                res_valid;
    logic                buf_full;
    ihrc_pkg::out_item_t res;

    assign in_stall = buf_full;
    assign item_take = in_valid && !buf_full;

    ihrc_parser #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_take   (item_take),
        .item        (in_item),
        .res_valid   (res_valid),
        .res         (res)
    );

    ihrc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ----- design/ihrc_parser.sv -----
// Header parser: byte position, captured fields, running checksum and counters.
// Computes at most one verdict per datagram from the accepted bytes in a single pass.
// Depends on ihrc_pkg.
`default_nettype none

module ihrc_parser #(
    parameter int COUNTER_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               item_take,
    input  wire ihrc_pkg::in_item_t item,
    output logic                    res_valid,
    output ihrc_pkg::out_item_t     res
);

    logic [31:0]             local_address_reg;
    logic [5:0]              byte_position_reg, byte_position_next;
    logic [3:0]              header_words_reg, header_words_next;
    logic [15:0]             checksum_sum_reg, checksum_sum_next;
    logic [7:0]              high_byte_hold_reg, high_byte_hold_next;
    logic [15:0]             length_field_reg, length_field_next;
    logic [7:0]              protocol_field_reg, protocol_field_next;
    logic [31:0]             sender_address_reg, sender_address_next;
    logic [7:0]              fragment_bits_reg, fragment_bits_next;
    logic                    ignoring_reg, ignoring_next;
    logic [COUNTER_BITS-1:0] packet_counter_reg, packet_counter_next;
    logic [COUNTER_BITS-1:0] drop_counter_reg, drop_counter_next;

    logic        active;
    logic        reject;
    logic        done;
    logic [2:0]  verdict;
    logic [5:0]  p;
    logic [7:0]  b;
    logic [16:0] sum_wide;
    logic [7:0]  want;
    logic [3:0]  hw_eff;
    logic [5:0]  last_pos;
    logic [5:0]  header_bytes;
    logic [31:0] rx_count32;
    logic [31:0] drop_count32;

    always_comb
    begin
        active = item_take && (item.start_req || !ignoring_reg);
        b = item.data_byte;

        byte_position_next  = byte_position_reg;
        header_words_next   = header_words_reg;
        checksum_sum_next   = checksum_sum_reg;
        high_byte_hold_next = high_byte_hold_reg;
        length_field_next   = length_field_reg;
        protocol_field_next = protocol_field_reg;
        sender_address_next = sender_address_reg;
        fragment_bits_next  = fragment_bits_reg;
        packet_counter_next = packet_counter_reg;
        drop_counter_next   = drop_counter_reg;

        if (item_take && item.start_req)
        begin
            packet_counter_next = packet_counter_reg + 1'b1;
            byte_position_next  = '0;
            header_words_next   = '0;
            checksum_sum_next   = '0;
            high_byte_hold_next = '0;
            length_field_next   = '0;
            protocol_field_next = '0;
            sender_address_next = '0;
            fragment_bits_next  = '0;
        end

        p = byte_position_next;
        sum_wide = '0;
        reject = 1'b0;
        verdict = ihrc_pkg::VERDICT_ACCEPT;

        case (p[1:0])
            2'd0:    want = local_address_reg[31:24];
            2'd1:    want = local_address_reg[23:16];
            2'd2:    want = local_address_reg[15:8];
            default: want = local_address_reg[7:0];
        endcase

        if (active)
        begin
            if (!p[0])
            begin
                high_byte_hold_next = b;
            end
            else
            begin
                sum_wide = {1'b0, checksum_sum_next} + {1'b0, high_byte_hold_next, b};
                checksum_sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end

            if (p == ihrc_pkg::POS_VERSION)
            begin
                if (b[7:4] != ihrc_pkg::IP_VERSION)
                begin
                    reject = 1'b1;
                    verdict = ihrc_pkg::VERDICT_BAD_VERSION;
                end
                else
                begin
                    header_words_next = b[3:0];
                end
            end
            else if (p == ihrc_pkg::POS_LEN_HI)
            begin
                length_field_next[15:8] = b;
            end
            else if (p == ihrc_pkg::POS_LEN_LO)
            begin
                length_field_next[7:0] = b;
            end
            else if (p == ihrc_pkg::POS_FRAG_HI)
            begin
                fragment_bits_next = b;
            end
            else if (p == ihrc_pkg::POS_FRAG_LO)
            begin
                if (({fragment_bits_next[4:0], b} != 13'd0) || fragment_bits_next[5])
                begin
                    reject = 1'b1;
                    verdict = ihrc_pkg::VERDICT_FRAGMENTED;
                end
            end
            else if (p == ihrc_pkg::POS_PROTOCOL)
            begin
                protocol_field_next = b;
            end
            else if (p inside {[ihrc_pkg::POS_SRC_FIRST:ihrc_pkg::POS_SRC_LAST]})
            begin
                sender_address_next = {sender_address_next[23:0], b};
            end
            else if (p inside {[ihrc_pkg::POS_DST_FIRST:ihrc_pkg::POS_DST_LAST]})
            begin
                if (b != want)
                begin
                    reject = 1'b1;
                    verdict = ihrc_pkg::VERDICT_WRONG_DEST;
                end
            end
        end

        hw_eff = (header_words_next < ihrc_pkg::MIN_HEADER_WORDS) ?
                 ihrc_pkg::MIN_HEADER_WORDS : header_words_next;
        header_bytes = {hw_eff, 2'b00};
        last_pos = header_bytes - 6'd1;

        done = 1'b0;
        if (active && !reject && (p == last_pos))
        begin
            if (checksum_sum_next != ihrc_pkg::CSUM_GOOD)
            begin
                reject = 1'b1;
                verdict = ihrc_pkg::VERDICT_BAD_CSUM;
            end
            else
            begin
                done = 1'b1;
            end
        end

        if (reject)
        begin
            drop_counter_next = drop_counter_reg + 1'b1;
        end

        res_valid = reject || done;

        if (active && !res_valid)
        begin
            byte_position_next = p + 6'd1;
        end

        if (res_valid)
        begin
            ignoring_next = 1'b1;
        end
        else if (active)
        begin
            ignoring_next = 1'b0;
        end
        else
        begin
            ignoring_next = ignoring_reg;
        end
    end

    generate
        if (COUNTER_BITS >= 32)
        begin : g_wide_count
            assign rx_count32   = packet_counter_next[31:0];
            assign drop_count32 = drop_counter_next[31:0];
        end
        else
        begin : g_narrow_count
            assign rx_count32   = {{(32-COUNTER_BITS){1'b0}}, packet_counter_next};
            assign drop_count32 = {{(32-COUNTER_BITS){1'b0}}, drop_counter_next};
        end
    endgenerate

    always_comb
    begin
        res = '0;
        res.verdict = verdict;
        res.received_count = rx_count32;
        res.dropped_count = drop_count32;
        if (done)
        begin
            res.route = ihrc_pkg::route_of(protocol_field_next);
            res.protocol = protocol_field_next;
            res.source_address = sender_address_next;
            res.total_length = length_field_next;
            res.payload_length = (length_field_next > {10'd0, header_bytes}) ?
                                 (length_field_next - {10'd0, header_bytes}) : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg  <= '0;
            byte_position_reg  <= '0;
            header_words_reg   <= '0;
            checksum_sum_reg   <= '0;
            high_byte_hold_reg <= '0;
            length_field_reg   <= '0;
            protocol_field_reg <= '0;
            sender_address_reg <= '0;
            fragment_bits_reg  <= '0;
            ignoring_reg       <= 1'b1;
            packet_counter_reg <= '0;
            drop_counter_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                local_address_reg <= cfg_wr_data;
            end
            byte_position_reg  <= byte_position_next;
            header_words_reg   <= header_words_next;
            checksum_sum_reg   <= checksum_sum_next;
            high_byte_hold_reg <= high_byte_hold_next;
            length_field_reg   <= length_field_next;
            protocol_field_reg <= protocol_field_next;
            sender_address_reg <= sender_address_next;
            fragment_bits_reg  <= fragment_bits_next;
            ignoring_reg       <= ignoring_next;
            packet_counter_reg <= packet_counter_next;
            drop_counter_reg   <= drop_counter_next;
        end
    end

    a_verdict_then_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> ignoring_reg)
        else $error("parser did not stop after a verdict");

    a_reject_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.verdict != ihrc_pkg::VERDICT_ACCEPT)) |->
        (res.source_address == 32'd0 && res.total_length == 16'd0 &&
         res.payload_length == 16'd0 && res.route == ihrc_pkg::ROUTE_ICMP))
        else $error("rejected item carries header fields");

    a_position_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        !ignoring_reg |-> (byte_position_reg <=
            6'({((header_words_reg < ihrc_pkg::MIN_HEADER_WORDS) ?
                 ihrc_pkg::MIN_HEADER_WORDS : header_words_reg), 2'b00} - 6'd1)))
        else $error("byte position ran past the header end");

endmodule

`default_nettype wire

// ----- design/ihrc_out_buf.sv -----
// Result register with a skid stage so the parser keeps taking bytes
// while a finished result waits. Depends on ihrc_pkg.
`default_nettype none

module ihrc_out_buf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                res_valid,
    input  wire ihrc_pkg::out_item_t res,
    output logic                     full,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ihrc_pkg::out_item_t      out_item
);

    logic                main_valid_reg, main_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    ihrc_pkg::out_item_t main_reg, main_next;
    ihrc_pkg::out_item_t skid_reg, skid_next;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next = main_reg;
        skid_next = skid_reg;
        if (!main_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                main_next = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next = res;
                main_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item = main_reg;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds an item while the output is empty");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !res_valid)
        else $error("result arrived while both stages were full");

    a_stalled_result_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && main_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result lost while the output was stalled");

endmodule

`default_nettype wire

// ----- dv/ihrc_checker.sv -----
// Checker for the IPv4 receive header check: watches both item channels and the config port,
// predicts each verdict from the accepted bytes and compares it with the block's output.
// Depends on ihrc_pkg.
module ihrc_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  ihrc_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_stall,
    input  ihrc_pkg::out_item_t out_item,
    output int                  fail_count,
    output int                  results_due,
    output int                  bytes_parsed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] own_addr;
    logic [5:0]  pos_r;
    logic [3:0]  ihl_r;
    logic [15:0] sum_r;
    logic [7:0]  hi_r;
    logic [15:0] tlen_r;
    logic [7:0]  proto_r;
    logic [31:0] src_r;
    logic [7:0]  flags_r;
    logic        waiting_start;
    logic [31:0] started_cnt;
    logic [31:0] dropped_cnt;

    ihrc_pkg::out_item_t expected_verdicts [$];

    function automatic ihrc_pkg::out_item_t close_datagram(input logic [2:0] code);
        ihrc_pkg::out_item_t r;
        logic [3:0]          words;
        logic [15:0]         hdr_bytes;
        r = '0;
        words = (ihl_r < ihrc_pkg::MIN_HEADER_WORDS) ? ihrc_pkg::MIN_HEADER_WORDS : ihl_r;
        hdr_bytes = {10'd0, words, 2'b00};
        if (code != ihrc_pkg::VERDICT_ACCEPT)
        begin
            dropped_cnt = dropped_cnt + 32'd1;
        end
        else
        begin
            case (proto_r)
                ihrc_pkg::PROTO_ICMP: r.route = ihrc_pkg::ROUTE_ICMP;
                ihrc_pkg::PROTO_UDP:  r.route = ihrc_pkg::ROUTE_UDP;
                ihrc_pkg::PROTO_TCP:  r.route = ihrc_pkg::ROUTE_TCP;
                default:              r.route = ihrc_pkg::ROUTE_OTHER;
            endcase
            r.protocol = proto_r;
            r.source_address = src_r;
            r.total_length = tlen_r;
            r.payload_length = (tlen_r > hdr_bytes) ? tlen_r - hdr_bytes : 16'd0;
        end
        r.verdict = code;
        r.received_count = started_cnt;
        r.dropped_count = dropped_cnt;
        waiting_start = 1'b1;
        return r;
    endfunction

    function automatic bit parse_byte(input ihrc_pkg::in_item_t it,
                                      output ihrc_pkg::out_item_t res);
        logic [7:0]  b;
        logic [5:0]  pos;
        logic [16:0] acc;
        logic [3:0]  words;
        logic [5:0]  last_pos;
        logic [12:0] frag_offset;
        logic [2:0]  code;
        bit          decided;
        int          shift;
        b = it.data_byte;
        res = '0;
        decided = 1'b0;
        code = ihrc_pkg::VERDICT_ACCEPT;
        if (it.start_req)
        begin
            started_cnt = started_cnt + 32'd1;
            pos_r = '0;
            ihl_r = '0;
            sum_r = '0;
            hi_r = '0;
            tlen_r = '0;
            proto_r = '0;
            src_r = '0;
            flags_r = '0;
            waiting_start = 1'b0;
        end
        else if (waiting_start)
        begin
            return 1'b0;
        end
        bytes_parsed++;
        pos = pos_r;
        if (!pos[0])
        begin
            hi_r = b;
        end
        else
        begin
            acc = {1'b0, sum_r} + {1'b0, hi_r, b};
            sum_r = acc[15:0] + {15'd0, acc[16]};
        end

        if (pos == ihrc_pkg::POS_VERSION)
        begin
            if (b[7:4] != ihrc_pkg::IP_VERSION)
            begin
                decided = 1'b1;
                code = ihrc_pkg::VERDICT_BAD_VERSION;
            end
            else
            begin
                ihl_r = b[3:0];
            end
        end
        else if (pos == ihrc_pkg::POS_LEN_HI)
        begin
            tlen_r[15:8] = b;
        end
        else if (pos == ihrc_pkg::POS_LEN_LO)
        begin
            tlen_r[7:0] = b;
        end
        else if (pos == ihrc_pkg::POS_FRAG_HI)
        begin
            flags_r = b;
        end
        else if (pos == ihrc_pkg::POS_FRAG_LO)
        begin
            frag_offset = {flags_r[4:0], b};
            if (frag_offset != '0 || flags_r[5])
            begin
                decided = 1'b1;
                code = ihrc_pkg::VERDICT_FRAGMENTED;
            end
        end
        else if (pos == ihrc_pkg::POS_PROTOCOL)
        begin
            proto_r = b;
        end
        else if (pos >= ihrc_pkg::POS_SRC_FIRST && pos <= ihrc_pkg::POS_SRC_LAST)
        begin
            src_r = {src_r[23:0], b};
        end
        else if (pos >= ihrc_pkg::POS_DST_FIRST && pos <= ihrc_pkg::POS_DST_LAST)
        begin
            shift = 8 * int'(ihrc_pkg::POS_DST_LAST - pos);
            if (b != own_addr[shift +: 8])
            begin
                decided = 1'b1;
                code = ihrc_pkg::VERDICT_WRONG_DEST;
            end
        end

        words = (ihl_r < ihrc_pkg::MIN_HEADER_WORDS) ? ihrc_pkg::MIN_HEADER_WORDS : ihl_r;
        last_pos = {words, 2'b00} - 6'd1;
        if (!decided && pos == last_pos)
        begin
            decided = 1'b1;
            code = (sum_r != ihrc_pkg::CSUM_GOOD) ? ihrc_pkg::VERDICT_BAD_CSUM :
                                                    ihrc_pkg::VERDICT_ACCEPT;
        end

        if (decided)
        begin
            res = close_datagram(code);
        end
        else
        begin
            pos_r = pos + 6'd1;
        end
        return decided;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ihrc_pkg::out_item_t want;
        ihrc_pkg::out_item_t fresh;
        if (!rst_n)
        begin
            own_addr = '0;
            pos_r = '0;
            ihl_r = '0;
            sum_r = '0;
            hi_r = '0;
            tlen_r = '0;
            proto_r = '0;
            src_r = '0;
            flags_r = '0;
            waiting_start = 1'b1;
            started_cnt = '0;
            dropped_cnt = '0;
            expected_verdicts.delete();
            fail_count = 0;
            bytes_parsed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("verdict", 32'(want.verdict), 32'(out_item.verdict));
                    check_field("route", 32'(want.route), 32'(out_item.route));
                    check_field("protocol", 32'(want.protocol), 32'(out_item.protocol));
                    check_field("source_address", want.source_address,
                                out_item.source_address);
                    check_field("total_length", 32'(want.total_length),
                                32'(out_item.total_length));
                    check_field("payload_length", 32'(want.payload_length),
                                32'(out_item.payload_length));
                    check_field("received_count", want.received_count,
                                out_item.received_count);
                    check_field("dropped_count", want.dropped_count, out_item.dropped_count);
                end
            end
            if (cfg_wr_en)
            begin
                own_addr = cfg_wr_data;
            end
            if (in_valid && !in_stall)
            begin
                if (parse_byte(in_item, fresh))
                begin
                    expected_verdicts.push_back(fresh);
                end
            end
        end
        results_due = expected_verdicts.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// Top of the IPv4 receive header check testbench: clock, reset, datagram stimulus,
// receiver stalls and the final verdict. Depends on ihrc_pkg, ihrc_checker and
// ipv4_header_receive_check_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {
        DG_GOOD,
        DG_BAD_VERSION,
        DG_FRAGMENT,
        DG_WRONG_DEST,
        DG_BAD_CSUM,
        DG_TRUNCATED
    } dg_kind_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [31:0]         cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    ihrc_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall;
    ihrc_pkg::out_item_t out_item;

    int          fail_count;
    int          results_due;
    int          bytes_parsed;

    logic [31:0] my_addr;
    bit          calm;
    bit          hold_req;
    int          dg_count;
    int          phase;

    ipv4_header_receive_check_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    ihrc_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item),
        .fail_count   (fail_count),
        .results_due  (results_due),
        .bytes_parsed (bytes_parsed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic dg_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return DG_GOOD;
        end
        else if (r < 68)
        begin
            return DG_BAD_VERSION;
        end
        else if (r < 76)
        begin
            return DG_FRAGMENT;
        end
        else if (r < 84)
        begin
            return DG_WRONG_DEST;
        end
        else if (r < 92)
        begin
            return DG_BAD_CSUM;
        end
        return DG_TRUNCATED;
    endfunction

    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_req && !hold_done)
            begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            else if (hold_left == 0 && !calm)
            begin
                hold_left = pick_stall();
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{data_byte: b, start_req: first};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (results_due == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_local(input logic [31:0] addr);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= addr;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        my_addr = addr;
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
        begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic send_datagram(input dg_kind_t kind, input int ihl_pick,
                                 input int proto_pick, input int tlen_pick);
        logic [7:0]  hdr [0:59];
        logic [31:0] sum;
        logic [15:0] csum;
        logic [15:0] tlen;
        logic [3:0]  ihl;
        int          span;
        int          sent;
        int          extra;
        int          i;
        int          k;
        int          r;
        ihl = (ihl_pick >= 0) ? 4'(ihl_pick) : 4'd5;
        if (ihl_pick < 0)
        begin
            r = $urandom_range(0, 9);
            if (r == 7)
            begin
                ihl = 4'($urandom_range(6, 15));
            end
            else if (r == 8)
            begin
                ihl = 4'($urandom_range(0, 4));
            end
        end
        span = ((ihl < ihrc_pkg::MIN_HEADER_WORDS) ? 5 : int'(ihl)) * 4;
        if (tlen_pick >= 0)
        begin
            tlen = 16'(tlen_pick);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                tlen = 16'(span + $urandom_range(0, 1480));
            end
            else if (r < 85)
            begin
                tlen = 16'($urandom_range(0, span));
            end
            else
            begin
                tlen = 16'($urandom_range(0, 65535));
            end
        end
        for (i = 0; i < span; i++)
        begin
            hdr[i] = 8'($urandom_range(0, 255));
        end
        hdr[0] = {ihrc_pkg::IP_VERSION, ihl};
        hdr[2] = tlen[15:8];
        hdr[3] = tlen[7:0];
        hdr[6] = {hdr[6][7:6], 6'd0};
        hdr[7] = 8'd0;
        if (proto_pick >= 0)
        begin
            hdr[9] = 8'(proto_pick);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: hdr[9] = ihrc_pkg::PROTO_ICMP;
                1: hdr[9] = ihrc_pkg::PROTO_UDP;
                2: hdr[9] = ihrc_pkg::PROTO_TCP;
                default: hdr[9] = 8'($urandom_range(0, 255));
            endcase
        end
        hdr[10] = 8'd0;
        hdr[11] = 8'd0;
        for (i = 0; i < 4; i++)
        begin
            hdr[16 + i] = my_addr[8 * (3 - i) +: 8];
        end
        sum = '0;
        for (i = 0; i < span; i += 2)
        begin
            sum = sum + {16'd0, hdr[i], hdr[i + 1]};
        end
        while (sum[31:16] != 0)
        begin
            sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
        end
        csum = ~sum[15:0];
        hdr[10] = csum[15:8];
        hdr[11] = csum[7:0];

        sent = span;
        case (kind)
            DG_BAD_VERSION:
            begin
                k = $urandom_range(0, 14);
                if (k >= int'(ihrc_pkg::IP_VERSION))
                begin
                    k++;
                end
                hdr[0][7:4] = 4'(k);
            end
            DG_FRAGMENT:
            begin
                case ($urandom_range(0, 2))
                    0: hdr[6][5] = 1'b1;
                    1: hdr[6][4:0] = 5'($urandom_range(1, 31));
                    default: hdr[7] = 8'($urandom_range(1, 255));
                endcase
            end
            DG_WRONG_DEST:
            begin
                k = $urandom_range(16, 19);
                hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
            end
            DG_BAD_CSUM:
            begin
                case ($urandom_range(0, 6))
                    0: k = 1;
                    1: k = 4;
                    2: k = 5;
                    3: k = 8;
                    4: k = 10;
                    5: k = 11;
                    default: k = (span > 20) ? $urandom_range(20, span - 1) : 10;
                endcase
                hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
            end
            DG_TRUNCATED:
            begin
                sent = $urandom_range(1, span - 1);
            end
            default:
            begin
            end
        endcase

        for (i = 0; i < sent; i++)
        begin
            push_byte(hdr[i], i == 0);
        end
        if (kind != DG_TRUNCATED)
        begin
            extra = $urandom_range(0, 4);
            for (i = 0; i < extra; i++)
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        dg_count++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        my_addr = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        dg_count = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_local(32'hC0A8_0A01);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        send_datagram(DG_GOOD, 5, int'(ihrc_pkg::PROTO_ICMP), 84);
        send_datagram(DG_GOOD, 5, int'(ihrc_pkg::PROTO_UDP), 65535);
        send_datagram(DG_GOOD, 5, int'(ihrc_pkg::PROTO_TCP), 0);
        send_datagram(DG_GOOD, 15, 255, 60);
        send_datagram(DG_GOOD, 0, 0, 19);
        send_datagram(DG_BAD_VERSION, 5, -1, -1);
        send_datagram(DG_FRAGMENT, 5, -1, -1);
        send_datagram(DG_WRONG_DEST, 5, -1, -1);
        send_datagram(DG_BAD_CSUM, 6, -1, -1);
        send_datagram(DG_TRUNCATED, 5, -1, -1);
        send_datagram(DG_GOOD, 5, int'(ihrc_pkg::PROTO_UDP), -1);
        drain();

        write_local(32'hFFFF_FFFF);
        calm = 1'b1;
        hold_req = 1'b1;
        repeat (20) send_datagram(DG_GOOD, -1, -1, -1);
        calm = 1'b0;
        drain();

        phase = 0;
        while (bytes_parsed < 1200 || dg_count < 60)
        begin
            case (phase % 4)
                0: write_local(32'h0000_0000);
                1: write_local(32'hFFFF_FFFF);
                default: write_local($urandom());
            endcase
            calm = (phase % 3 == 2);
            repeat (8)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_noise();
                end
                send_datagram(pick_kind(), -1, -1, -1);
            end
            calm = 1'b0;
            drain();
            phase++;
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0 && results_due == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
